// ===== sv/mmrn_pkg.sv =====
// Package for the min/max range normalizer: widths, depths and the queue entry type.
// No dependencies.
package mmrn_pkg;
  localparam int unsigned MaxSamples = 64;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned AddrBits   = $clog2(MaxSamples);
  localparam int unsigned CountBits  = $clog2(MaxSamples + 1);
  localparam int unsigned RangeBits  = SampleBits + 1;
  localparam int unsigned LevelBits  = 8;
  localparam int unsigned ScaleBits  = 8;
  localparam int unsigned NumBits    = RangeBits + ScaleBits + 2;
  localparam int unsigned QuotBits   = ScaleBits + 1;
  localparam int unsigned StepBits   = $clog2(QuotBits + 1);
  localparam logic [ScaleBits-1:0] FullScaleReset = ScaleBits'(70);

  // one closed set, handed from the loader to the emitter
  typedef struct packed {
    logic [CountBits-1:0]        count;
    logic signed [SampleBits-1:0] min_val;
    logic [RangeBits-1:0]        range;
  } set_desc_t;
endpackage

// ===== sv/mmrn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmrn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/mmrn_front.sv =====
// Loader: stores samples, tracks min/max, posts a set descriptor on the last beat.
// Depends on mmrn_pkg.
module mmrn_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mmrn_pkg::SampleBits-1:0] sample_i,
  input  logic                                  last_i,
  input  logic                                  busy_i,
  output logic                                  we_o,
  output logic [mmrn_pkg::AddrBits-1:0]         waddr_o,
  output logic                                  post_o,
  output mmrn_pkg::set_desc_t                   desc_o
);
  logic [mmrn_pkg::CountBits-1:0] cnt_q, cnt_d;
  logic signed [mmrn_pkg::SampleBits-1:0] min_q, min_d, max_q, max_d;
  logic acc, room;

  // the store is shared with the emitter, so loading waits for it to drain
  assign in_stall_o = busy_i;
  assign acc  = in_valid_i && !busy_i;
  assign room = cnt_q < mmrn_pkg::CountBits'(mmrn_pkg::MaxSamples);
  assign we_o = acc && room;
  assign waddr_o = cnt_q[mmrn_pkg::AddrBits-1:0];

  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    max_d = max_q;
    if (we_o) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '0) begin
        min_d = sample_i;
        max_d = sample_i;
      end else begin
        if (sample_i < min_q) min_d = sample_i;
        if (sample_i > max_q) max_d = sample_i;
      end
    end
  end

  assign post_o        = acc && last_i;
  assign desc_o.count  = cnt_d;
  assign desc_o.min_val = min_d;
  assign desc_o.range  = mmrn_pkg::RangeBits'(
    {max_d[mmrn_pkg::SampleBits-1], max_d} - {min_d[mmrn_pkg::SampleBits-1], min_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else if (post_o) begin
      cnt_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mmrn_pkg::CountBits'(mmrn_pkg::MaxSamples)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !we_o) else $error("store written while emitting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q)) else $error("min above max");
endmodule

// ===== sv/mmrn_back.sv =====
// Emitter: reads the store in load order and divides out each level bit-serially.
// Depends on mmrn_pkg.
module mmrn_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [mmrn_pkg::ScaleBits-1:0]        full_scale_i,
  input  logic                                  desc_valid_i,
  input  mmrn_pkg::set_desc_t                   desc_i,
  output logic                                  desc_pop_o,
  output logic [mmrn_pkg::AddrBits-1:0]         raddr_o,
  input  logic signed [mmrn_pkg::SampleBits-1:0] rdata_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mmrn_pkg::LevelBits-1:0]        level_o,
  output logic                                  flat_o,
  output logic                                  end_of_set_o
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_OUT} state_e;

  state_e state_q;
  mmrn_pkg::set_desc_t set_q;
  logic [mmrn_pkg::CountBits-1:0] idx_q;
  logic [mmrn_pkg::NumBits-1:0] rem_q;
  logic [mmrn_pkg::QuotBits-1:0] quo_q;
  logic [mmrn_pkg::StepBits-1:0] step_q;
  logic [mmrn_pkg::NumBits-1:0] den_sh;
  logic [mmrn_pkg::RangeBits-1:0] diff;
  logic flat, last_one;

  assign flat     = set_q.range == '0;
  assign last_one = (idx_q + 1'b1) == set_q.count;
  assign raddr_o  = idx_q[mmrn_pkg::AddrBits-1:0];
  assign desc_pop_o = (state_q == S_IDLE) && desc_valid_i;
  assign diff = mmrn_pkg::RangeBits'(
    {rdata_i[mmrn_pkg::SampleBits-1], rdata_i} -
    {set_q.min_val[mmrn_pkg::SampleBits-1], set_q.min_val});
  // 2*range shifted to the current quotient bit
  assign den_sh = mmrn_pkg::NumBits'({set_q.range, 1'b0}) << (step_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      step_q       <= '0;
      out_valid_o  <= 1'b0;
      set_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      level_o      <= '0;
      flat_o       <= 1'b0;
      end_of_set_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            set_q   <= desc_i;
            idx_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_MUL;
        S_MUL: begin
          rem_q  <= ((mmrn_pkg::NumBits'(diff) * mmrn_pkg::NumBits'(full_scale_i)) << 1) +
                    mmrn_pkg::NumBits'(set_q.range);
          quo_q  <= '0;
          step_q <= mmrn_pkg::StepBits'(mmrn_pkg::QuotBits);
          state_q <= flat ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (rem_q >= den_sh) begin
            rem_q <= rem_q - den_sh;
            quo_q <= {quo_q[mmrn_pkg::QuotBits-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[mmrn_pkg::QuotBits-2:0], 1'b0};
          end
          step_q <= step_q - 1'b1;
          if (step_q == mmrn_pkg::StepBits'(1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_o) begin
            out_valid_o  <= 1'b1;
            level_o      <= flat ? '0 : mmrn_pkg::LevelBits'(quo_q);
            flat_o       <= flat;
            end_of_set_o <= last_one;
          end else if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            idx_q       <= idx_q + 1'b1;
            state_q     <= last_one ? S_IDLE : S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT) else $error("beat outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flat_o) |-> level_o == '0) else $error("flat level nonzero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= full_scale_i) else $error("level above full scale");
endmodule

// ===== sv/min_max_range_normalizer.sv =====
// Top level of the min/max range normalizer: loader, descriptor queue, store, emitter.
// Depends on mmrn_pkg, mmrn_ram, mmrn_front, mmrn_back.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid_i/in_stall_o   | sample_i, last_i
//   out     | output    | out_valid_o/out_stall_i | level_o, flat_o, end_of_set_o
//   cfg     | input     | full_scale_we_i         | full_scale_i
//
// Loading takes one cycle per sample. After the last beat each level passes
// through a store read, a multiply, 9 restoring division steps and the output
// register, plus any output stalls; a flat set skips the division.
// Input stalls while a set is queued or being emitted.
// Reset clears counters, min/max and full_scale to 70; the store is not cleared.
module min_max_range_normalizer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   full_scale_we_i,
  input  logic [mmrn_pkg::ScaleBits-1:0]         full_scale_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mmrn_pkg::SampleBits-1:0] sample_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [mmrn_pkg::LevelBits-1:0]         level_o,
  output logic                                   flat_o,
  output logic                                   end_of_set_o
);
  logic [mmrn_pkg::ScaleBits-1:0] fs_q;
  logic we, post, pop, qv_q, busy;
  logic [mmrn_pkg::AddrBits-1:0] waddr, raddr;
  logic [mmrn_pkg::SampleBits-1:0] rdata;
  mmrn_pkg::set_desc_t desc, q_q;
  logic back_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fs_q <= mmrn_pkg::FullScaleReset;
    else if (full_scale_we_i) fs_q <= full_scale_i;
  end

  // one-entry descriptor queue; back_busy marks a set still emitting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= 1'b0;
      q_q  <= '0;
      back_busy_q <= 1'b0;
    end else begin
      if (post) begin
        qv_q <= 1'b1;
        q_q  <= desc;
      end else if (pop) begin
        qv_q <= 1'b0;
      end
      if (pop) back_busy_q <= 1'b1;
      else if (out_valid_o && !out_stall_i && end_of_set_o) back_busy_q <= 1'b0;
    end
  end
  assign busy = qv_q || back_busy_q;

  mmrn_ram #(.Width(mmrn_pkg::SampleBits), .Depth(mmrn_pkg::MaxSamples)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(sample_i),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mmrn_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_i, .last_i,
    .busy_i(busy), .we_o(we), .waddr_o(waddr), .post_o(post), .desc_o(desc)
  );

  mmrn_back u_back (
    .clk_i, .rst_ni, .full_scale_i(fs_q), .desc_valid_i(qv_q), .desc_i(q_q),
    .desc_pop_o(pop), .raddr_o(raddr), .rdata_i($signed(rdata)),
    .out_valid_o, .out_stall_i, .level_o, .flat_o, .end_of_set_o
  );
endmodule
